// File: rtl/stli_pkg.sv
// Shared types and constants for the sorted table interpolator.
package stli_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned CountW = $clog2(TableDepth + 1);
  localparam int unsigned FractionBits = 8;

  localparam logic [1:0] CmdLoad = 2'd0;
  localparam logic [1:0] CmdQuery = 2'd1;
  localparam logic [1:0] CmdClear = 2'd2;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StRange = 3'd1;
  localparam logic [2:0] StEmpty = 3'd2;
  localparam logic [2:0] StFull = 3'd3;
  localparam logic [2:0] StSat = 3'd4;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } entry_t;

  typedef struct packed {
    logic               start;
    logic signed [32:0] num;
    logic        [16:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [32:0] quot;
  } div_rsp_t;

endpackage

// File: rtl/sorted_table_linear_interpolator_unit.sv
// Sorted breakpoint table with piecewise linear interpolation, top level.
// One item at a time. A load moves larger entries up with a read and a write per moved entry
// on the single port; a query scans the table and, to interpolate between two entries, runs
// the bit-serial divider; clear and other commands go straight to the output.
// The next item is taken in the cycle after the result transfer.
// Reset empties the table at once; the memory itself is not cleared.
module sorted_table_linear_interpolator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // command[1:0], x_value[17:2], y_value[33:18]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o   // y_result[15:0], status[18:16]
);

  localparam int unsigned AW = stli_pkg::AddrW;
  localparam int unsigned CW = stli_pkg::CountW;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FIND  = 7'b0000010,
    S_SHIFT = 7'b0000100,
    S_QSCAN = 7'b0001000,
    S_QDIV  = 7'b0010000,
    S_QWAIT = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic signed [15:0] x_q, x_d, y_q, y_d;
  stli_pkg::entry_t prev_q, prev_d;
  stli_pkg::entry_t hold_q, hold_d;
  logic have_prev_q, have_prev_d;
  logic pend_q, pend_d;
  logic signed [15:0] res_q, res_d;
  logic [2:0] st_q, st_d;
  logic ovalid_q, ovalid_d;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  stli_pkg::entry_t ram_wdata, ram_rdata;
  stli_pkg::div_req_t dreq;
  stli_pkg::div_rsp_t drsp;
  logic signed [17:0] sum;
  logic signed [16:0] dx;
  logic signed [16:0] dy;

  stli_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  stli_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (dreq),
    .rsp_o (drsp)
  );

  assign s_axis_tready_o = (state_q == S_IDLE) && !ovalid_q;
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o = {5'd0, st_q, res_q};

  assign dx = 17'(x_q) - 17'(prev_q.x);
  assign dy = 17'(hold_q.y) - 17'(prev_q.y);
  assign sum = 18'(prev_q.y) + 18'(drsp.quot);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    x_d         = x_q;
    y_d         = y_q;
    prev_d      = prev_q;
    hold_d      = hold_q;
    have_prev_d = have_prev_q;
    pend_d      = 1'b0;
    res_d       = res_q;
    st_d        = st_q;
    ovalid_d    = ovalid_q;
    ram_we      = 1'b0;
    ram_addr    = idx_q[AW-1:0];
    ram_wdata   = '{x: x_q, y: y_q};
    dreq.start  = 1'b0;
    dreq.num    = 33'(dx) * 33'(dy);
    dreq.den    = dx == 0 ? 17'd1 : 17'(hold_q.x) - 17'(prev_q.x);
    if (ovalid_q && m_axis_tready_i) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i && !ovalid_q) begin
          x_d   = s_axis_tdata_i[17:2];
          y_d   = s_axis_tdata_i[33:18];
          idx_d = '0;
          have_prev_d = 1'b0;
          res_d = '0;
          st_d  = stli_pkg::StOk;
          case (s_axis_tdata_i[1:0])
            stli_pkg::CmdLoad: begin
              if (count_q >= CW'(stli_pkg::TableDepth)) begin
                st_d = stli_pkg::StFull;
                state_d = S_OUT;
              end else if (count_q == '0) begin
                state_d = S_SHIFT;
                idx_d = '0;
              end else begin
                state_d = S_FIND;
                pend_d = 1'b1;
              end
            end
            stli_pkg::CmdQuery: begin
              if (count_q == '0) begin
                st_d = stli_pkg::StEmpty;
                state_d = S_OUT;
              end else begin
                ram_addr = '0;
                state_d = S_QSCAN;
                pend_d = 1'b1;
              end
            end
            stli_pkg::CmdClear: begin
              count_d = '0;
              state_d = S_OUT;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      // Walk down from the top, moving larger entries up one slot.
      S_FIND: begin
        if (!pend_q) begin
          ram_addr = AW'(count_q - CW'(1));
          idx_d = count_q;
          pend_d = 1'b1;
          state_d = S_SHIFT;
        end else begin
          ram_addr = AW'(count_q - CW'(1));
          idx_d = count_q;
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (idx_q == '0 || (!pend_q && !have_prev_q) || (pend_q && ram_rdata.x <= x_q)) begin
          if (idx_q != '0 && !pend_q) begin
            ram_addr = AW'(idx_q - CW'(1));
            pend_d = 1'b1;
            have_prev_d = 1'b1;
          end else begin
            ram_we = 1'b1;
            ram_addr = idx_q[AW-1:0];
            ram_wdata = '{x: x_q, y: y_q};
            count_d = count_q + CW'(1);
            state_d = S_OUT;
          end
        end else begin
          ram_we = 1'b1;
          ram_addr = idx_q[AW-1:0];
          ram_wdata = ram_rdata;
          idx_d = idx_q - CW'(1);
          have_prev_d = 1'b0;
        end
      end
      // Scan upward; prev holds the last entry below x, hold the first one above it.
      S_QSCAN: begin
        if (!pend_q) begin
          ram_addr = idx_q[AW-1:0];
          pend_d = 1'b1;
        end else if (ram_rdata.x == x_q) begin
          res_d = ram_rdata.y;
          state_d = S_OUT;
        end else if (ram_rdata.x > x_q) begin
          if (!have_prev_q) begin
            st_d = stli_pkg::StRange;
            state_d = S_OUT;
          end else begin
            hold_d = ram_rdata;
            state_d = S_QDIV;
          end
        end else begin
          prev_d = ram_rdata;
          have_prev_d = 1'b1;
          if (idx_q == count_q - CW'(1)) begin
            st_d = stli_pkg::StRange;
            state_d = S_OUT;
          end else begin
            idx_d = idx_q + CW'(1);
            ram_addr = AW'(idx_q + CW'(1));
            pend_d = 1'b1;
          end
        end
      end
      S_QDIV: begin
        dreq.start = 1'b1;
        state_d = S_QWAIT;
      end
      S_QWAIT: begin
        if (drsp.done) begin
          if (sum > 18'sd32767) begin
            res_d = 16'sh7fff;
            st_d = stli_pkg::StSat;
          end else if (sum < -18'sd32768) begin
            res_d = -16'sh8000;
            st_d = stli_pkg::StSat;
          end else begin
            res_d = sum[15:0];
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        ovalid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ovalid_q <= 1'b0;
      pend_q   <= 1'b0;
      have_prev_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
      pend_q   <= pend_d;
      have_prev_q <= have_prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    x_q    <= x_d;
    y_q    <= y_d;
    prev_q <= prev_d;
    hold_q <= hold_d;
    res_q  <= res_d;
    st_q   <= st_d;
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(stli_pkg::TableDepth)) else $error("entry count overflow");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !s_axis_tready_o) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !m_axis_tready_i |=> ovalid_q && $stable(m_axis_tdata_o))
    else $error("result dropped");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> count_q == '0 || count_q == $past(count_q) + CW'(1))
    else $error("bad count step");

endmodule

// File: rtl/stli_ram.sv
// Single-port table memory with registered read data.
module stli_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [stli_pkg::AddrW-1:0] addr_i,
  input  stli_pkg::entry_t           wdata_i,
  output stli_pkg::entry_t           rdata_o
);

  stli_pkg::entry_t mem [stli_pkg::TableDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// File: rtl/stli_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module stli_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stli_pkg::div_req_t  req_i,
  output stli_pkg::div_rsp_t  rsp_o
);

  logic [32:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [16:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] trial;
  logic [31:0] mag;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    mag    = req_i.num[32] ? 32'(-req_i.num) : req_i.num[31:0];
    trial  = {rem_q[31:0], quo_q[31]} - {16'd0, den_q};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = mag;
      den_d  = req_i.den;
      neg_d  = req_i.num[32];
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule
